@@ sv/ib_pkg.sv @@
// Shared constants, types and angle table for the initial bearing block.
`default_nettype none
package ib_pkg;
	localparam int FRAC_BITS    = 22;
	localparam int CORDIC_STEPS = 24;
	localparam int ANG_TAB_LEN  = 31;

	localparam int LAT_W  = 30;
	localparam int LON_W  = 31;
	localparam int BEAR_W = 31;

	// binary angle, 2^32 is one turn
	localparam int ANG_W = 32;
	// CORDIC datapath and residual angle
	localparam int DW    = 36;
	localparam int ZW    = ANG_W + 1;
	localparam int SH_W  = $clog2(ANG_TAB_LEN);
	// multiplier operand width
	localparam int MW    = 32;
	// degrees mod one turn, signed, with room for the longitude difference
	localparam int MODW  = 34;
	// degrees scaled into eighths of a binary angle times 45
	localparam int WW    = 38;
	// binary angle times 360 on the way out
	localparam int DGW   = ANG_W + 9;

	localparam int NLANE  = 3;
	localparam int LANE_A = 0;
	localparam int LANE_B = 1;
	localparam int LANE_D = 2;

	localparam longint FULL_DEG = longint'(360) << FRAC_BITS;
	localparam logic signed [DW-1:0] GAIN = DW'(652032874);
	// floor(2^37 / 45)
	localparam logic [31:0] RECIP = 32'((64'd1 << 37) / 64'd45);

	localparam logic [ANG_W-1:0] ANG_TAB [ANG_TAB_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
	};

	typedef logic signed [DW-1:0] dat_t;
	typedef logic signed [ZW-1:0] zang_t;

	typedef struct packed {
		logic [1:0] qa;
		logic [1:0] qb;
		logic [1:0] qd;
		logic       same;
	} rot_side_t;
endpackage
`default_nettype wire

@@ sv/ib_in_if.sv @@
// Request channel carrying the two points.
`default_nettype none
interface ib_in_if;
	import ib_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [LAT_W-1:0] start_lat;
	logic signed [LON_W-1:0] start_lon;
	logic signed [LAT_W-1:0] end_lat;
	logic signed [LON_W-1:0] end_lon;
	modport source (output valid, start_lat, start_lon, end_lat, end_lon, input ready);
	modport sink (input valid, start_lat, start_lon, end_lat, end_lon, output ready);
endinterface
`default_nettype wire

@@ sv/ib_out_if.sv @@
// Result channel carrying the bearing.
`default_nettype none
interface ib_out_if;
	import ib_pkg::*;
	logic              valid;
	logic              ready;
	logic [BEAR_W-1:0] bearing;
	modport source (output valid, bearing, input ready);
	modport sink (input valid, bearing, output ready);
endinterface
`default_nettype wire

@@ sv/ib_cell.sv @@
// One CORDIC micro-rotation with its output register.
`default_nettype none
module ib_cell (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic                    vec,
	input  wire logic [ib_pkg::SH_W-1:0]  shift,
	input  wire logic [ib_pkg::ANG_W-1:0] ang,
	input  wire ib_pkg::dat_t             x_cur,
	input  wire ib_pkg::dat_t             y_cur,
	input  wire ib_pkg::zang_t            z_cur,
	output ib_pkg::dat_t                  x_s1,
	output ib_pkg::dat_t                  y_s1,
	output ib_pkg::zang_t                 z_s1
);
	import ib_pkg::*;

	dat_t  xs;
	dat_t  ys;
	zang_t za;
	logic  up;

	// rotation steers on the residual sign, vectoring on y
	always_comb begin
		xs = x_cur >>> shift;
		ys = y_cur >>> shift;
		za = zang_t'({1'b0, ang});
		up = vec ? !(y_cur > 0) : !z_cur[ZW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (up) begin
				x_s1 <= x_cur - ys;
				y_s1 <= y_cur + xs;
				z_s1 <= z_cur - za;
			end else begin
				x_s1 <= x_cur + ys;
				y_s1 <= y_cur - xs;
				z_s1 <= z_cur + za;
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/ib_rot.sv @@
// Sine/cosine chain: three lanes of rotation cells, one step per stage.
`default_nettype none
module ib_rot (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    valid,
	output logic                         ready,
	input  wire ib_pkg::rot_side_t        side,
	input  wire logic [ib_pkg::ANG_W-3:0] turn [ib_pkg::NLANE],
	output logic                         done,
	input  wire logic                    next_ready,
	output ib_pkg::rot_side_t             side_s,
	output ib_pkg::dat_t                  cx [ib_pkg::NLANE],
	output ib_pkg::dat_t                  sy [ib_pkg::NLANE]
);
	import ib_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic [N-1:0] v_s;
	logic [N:0]   en;
	rot_side_t    sd_s [N];
	dat_t         x_i  [N][NLANE];
	dat_t         y_i  [N][NLANE];
	zang_t        z_i  [N][NLANE];
	dat_t         x_s  [N][NLANE];
	dat_t         y_s  [N][NLANE];
	zang_t        z_s  [N][NLANE];

	assign en[N] = next_ready;
	assign ready = en[0];
	assign done  = v_s[N-1];
	assign side_s = sd_s[N-1];

	for (genvar k = 0; k < N; k++) begin : g_stage
		assign en[k] = !v_s[k] || en[k+1];

		if (k == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= valid;
				end
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					sd_s[k] <= side;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					sd_s[k] <= sd_s[k-1];
				end
			end
		end

		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			if (k == 0) begin : g_src
				assign x_i[k][l] = GAIN;
				assign y_i[k][l] = '0;
				assign z_i[k][l] = zang_t'({3'b000, turn[l]});
			end else begin : g_link
				assign x_i[k][l] = x_s[k-1][l];
				assign y_i[k][l] = y_s[k-1][l];
				assign z_i[k][l] = z_s[k-1][l];
			end

			ib_cell u_cell (
				.clk   (clk),
				.en    (en[k]),
				.vec   (1'b0),
				.shift (SH_W'(k)),
				.ang   (ANG_TAB[k]),
				.x_cur (x_i[k][l]),
				.y_cur (y_i[k][l]),
				.z_cur (z_i[k][l]),
				.x_s1  (x_s[k][l]),
				.y_s1  (y_s[k][l]),
				.z_s1  (z_s[k][l])
			);
		end
	end

	for (genvar l = 0; l < NLANE; l++) begin : g_out
		assign cx[l] = x_s[N-1][l];
		assign sy[l] = y_s[N-1][l];
	end
endmodule
`default_nettype wire

@@ sv/ib_vec.sv @@
// atan2 chain: vectoring cells, one step per stage.
`default_nettype none
module ib_vec (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     valid,
	output logic                          ready,
	input  wire logic                     zero,
	input  wire ib_pkg::dat_t              x,
	input  wire ib_pkg::dat_t              y,
	input  wire ib_pkg::zang_t             z,
	output logic                          done,
	input  wire logic                     next_ready,
	output logic                          zero_s,
	output logic [ib_pkg::ANG_W-1:0]       ang_s
);
	import ib_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic [N-1:0] v_s;
	logic [N-1:0] zr_s;
	logic [N:0]   en;
	dat_t         x_i [N];
	dat_t         y_i [N];
	zang_t        z_i [N];
	dat_t         x_s [N];
	dat_t         y_s [N];
	zang_t        z_s [N];

	assign en[N]  = next_ready;
	assign ready  = en[0];
	assign done   = v_s[N-1];
	assign zero_s = zr_s[N-1];
	assign ang_s  = z_s[N-1][ANG_W-1:0];

	for (genvar k = 0; k < N; k++) begin : g_stage
		assign en[k] = !v_s[k] || en[k+1];

		if (k == 0) begin : g_head
			assign x_i[k] = x;
			assign y_i[k] = y;
			assign z_i[k] = z;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= valid;
				end
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					zr_s[k] <= zero;
				end
			end
		end else begin : g_body
			assign x_i[k] = x_s[k-1];
			assign y_i[k] = y_s[k-1];
			assign z_i[k] = z_s[k-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					zr_s[k] <= zr_s[k-1];
				end
			end
		end

		ib_cell u_cell (
			.clk   (clk),
			.en    (en[k]),
			.vec   (1'b1),
			.shift (SH_W'(k)),
			.ang   (ANG_TAB[k]),
			.x_cur (x_i[k]),
			.y_cur (y_i[k]),
			.z_cur (z_i[k]),
			.x_s1  (x_s[k]),
			.y_s1  (y_s[k]),
			.z_s1  (z_s[k])
		);
	end
endmodule
`default_nettype wire

@@ sv/initial_bearing.sv @@
// Initial great-circle bearing: top level with angle conversion, products and output.
//
//   channel   dir   payload                                    accepted when
//   points    in    start_lat start_lon end_lat end_lon        valid && ready
//   result    out   bearing                                    valid && ready
//
// Fully pipelined: one request per cycle while result.ready does not hold the output.
// Requests pass through the two cell chains, one rotation step and one vectoring
// step per stage, plus conversion, product and output stages.
// Reset clears only valid bits; data registers are not reset.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and requests are still taken while a result waits at the output.
`default_nettype none
module initial_bearing (
	input  wire logic clk,
	input  wire logic arst_n,
	ib_in_if.sink     points,
	ib_out_if.source  result
);
	import ib_pkg::*;

	localparam logic signed [MODW-1:0] FULL_M = MODW'(FULL_DEG);
	localparam logic [DGW-1:0]         FULL_D = DGW'(FULL_DEG);
	localparam logic [DGW-1:0]         RND_O  = DGW'(1) << (31 - FRAC_BITS);
	localparam logic signed [2*MW-1:0] RND_M  = (2*MW)'(1) <<< 29;

	// degrees mod one turn, then scaled so that /45 gives the binary angle
	function automatic logic [WW-1:0] to_w(input logic signed [MODW-1:0] v);
		logic signed [MODW-1:0] m;
		priority if (v >= FULL_M) begin
			m = v - FULL_M;
		end else if (v >= 0) begin
			m = v;
		end else if (v >= -FULL_M) begin
			m = v + FULL_M;
		end else begin
			m = v + (FULL_M <<< 1);
		end
		return (WW'(m) << (29 - FRAC_BITS)) + WW'(22);
	endfunction

	function automatic dat_t cos_of(input dat_t x, input dat_t y, input logic [1:0] q);
		dat_t r;
		unique case (q)
			2'd0:    r = x;
			2'd1:    r = -y;
			2'd2:    r = -x;
			default: r = y;
		endcase
		return r;
	endfunction

	function automatic dat_t sin_of(input dat_t x, input dat_t y, input logic [1:0] q);
		dat_t r;
		unique case (q)
			2'd0:    r = y;
			2'd1:    r = x;
			2'd2:    r = -y;
			default: r = -x;
		endcase
		return r;
	endfunction

	// Q30 product, round half up
	function automatic dat_t mulq(input dat_t a, input dat_t b);
		logic signed [MW-1:0]   aa;
		logic signed [MW-1:0]   bb;
		logic signed [2*MW-1:0] p;
		aa = MW'(a);
		bb = MW'(b);
		p  = aa * bb + RND_M;
		return DW'(p >>> 30);
	endfunction

	// stage enables
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_o;
	logic rot_ready, rot_done, vec_ready, vec_done;

	// conversion to binary angles
	logic             v_s1, v_s2, v_s3;
	logic [WW-1:0]    w_s1  [NLANE];
	logic [31:0]      q0_s2 [NLANE];
	logic [7:0]       wl_s2 [NLANE];
	logic [7:0]       r_c   [NLANE];
	logic [ANG_W-1:0] t_s3  [NLANE];
	logic signed [MODW-1:0] ang_c [NLANE];
	logic signed [LON_W:0]  dl;

	always_comb begin
		dl = {points.end_lon[LON_W-1], points.end_lon}
			- {points.start_lon[LON_W-1], points.start_lon};
		ang_c[LANE_A] = MODW'(points.start_lat);
		ang_c[LANE_B] = MODW'(points.end_lat);
		ang_c[LANE_D] = MODW'(dl);
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NLANE; l++) begin
			if (en_s1) begin
				w_s1[l] <= to_w(ang_c[l]);
			end
			if (en_s2) begin
				q0_s2[l] <= 32'((64'(w_s1[l][WW-1:6]) * 64'(RECIP)) >> 31);
				wl_s2[l] <= w_s1[l][7:0];
			end
		end
	end

	// estimate is at most two low; the remainder fits in eight bits
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			r_c[l] = wl_s2[l] - 8'(q0_s2[l][7:0] * 8'd45);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NLANE; l++) begin
			if (en_s3) begin
				t_s3[l] <= q0_s2[l] + ANG_W'(r_c[l] >= 8'd45) + ANG_W'(r_c[l] >= 8'd90);
			end
		end
	end

	rot_side_t        rside;
	logic [ANG_W-3:0] rturn [NLANE];
	rot_side_t        rside_s;
	dat_t             rcx [NLANE];
	dat_t             rsy [NLANE];

	always_comb begin
		rside.qa   = t_s3[LANE_A][ANG_W-1:ANG_W-2];
		rside.qb   = t_s3[LANE_B][ANG_W-1:ANG_W-2];
		rside.qd   = t_s3[LANE_D][ANG_W-1:ANG_W-2];
		rside.same = (t_s3[LANE_A] == t_s3[LANE_B]) && (t_s3[LANE_D] == '0);
		for (int l = 0; l < NLANE; l++) begin
			rturn[l] = t_s3[l][ANG_W-3:0];
		end
	end

	ib_rot u_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (v_s3),
		.ready      (rot_ready),
		.side       (rside),
		.turn       (rturn),
		.done       (rot_done),
		.next_ready (en_s4),
		.side_s     (rside_s),
		.cx         (rcx),
		.sy         (rsy)
	);

	// products
	logic v_s4, v_s5, v_s6, v_s7;
	dat_t sa, ca, sb, cb, sd, cd;
	dat_t py_s4, t1_s4, m2_s4, cd_s4;
	dat_t py_s5, m2_s5, t2_s5;
	dat_t py_s6, px_s6;
	dat_t x_s7, y_s7;
	zang_t z_s7;
	logic same_s4, same_s5, same_s6, zero_s7;

	always_comb begin
		sa = sin_of(rcx[LANE_A], rsy[LANE_A], rside_s.qa);
		ca = cos_of(rcx[LANE_A], rsy[LANE_A], rside_s.qa);
		sb = sin_of(rcx[LANE_B], rsy[LANE_B], rside_s.qb);
		cb = cos_of(rcx[LANE_B], rsy[LANE_B], rside_s.qb);
		sd = sin_of(rcx[LANE_D], rsy[LANE_D], rside_s.qd);
		cd = cos_of(rcx[LANE_D], rsy[LANE_D], rside_s.qd);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			py_s4   <= mulq(sd, cb);
			t1_s4   <= mulq(sa, cb);
			m2_s4   <= mulq(ca, sb);
			cd_s4   <= cd;
			same_s4 <= rside_s.same;
		end
		if (en_s5) begin
			py_s5   <= py_s4;
			m2_s5   <= m2_s4;
			t2_s5   <= mulq(t1_s4, cd_s4);
			same_s5 <= same_s4;
		end
		if (en_s6) begin
			py_s6   <= py_s5;
			px_s6   <= m2_s5 - t2_s5;
			same_s6 <= same_s5;
		end
		if (en_s7) begin
			// left half-plane: turn the vector round and start at half a turn
			x_s7    <= px_s6[DW-1] ? -px_s6 : px_s6;
			y_s7    <= px_s6[DW-1] ? -py_s6 : py_s6;
			z_s7    <= px_s6[DW-1] ? zang_t'(33'h080000000) : '0;
			zero_s7 <= same_s6 || ((px_s6 == '0) && (py_s6 == '0));
		end
	end

	logic             vzero_s;
	logic [ANG_W-1:0] vang_s;

	ib_vec u_vec (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (v_s7),
		.ready      (vec_ready),
		.zero       (zero_s7),
		.x          (x_s7),
		.y          (y_s7),
		.z          (z_s7),
		.done       (vec_done),
		.next_ready (en_o),
		.zero_s     (vzero_s),
		.ang_s      (vang_s)
	);

	// binary angle to degrees
	logic [DGW-1:0]    dz;
	logic [DGW-1:0]    deg;
	logic              out_v_q;
	logic [BEAR_W-1:0] bearing_q;

	always_comb begin
		dz  = DGW'(vang_s);
		deg = ((dz << 8) + (dz << 6) + (dz << 5) + (dz << 3) + RND_O) >> (32 - FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			bearing_q <= (vzero_s || (deg >= FULL_D)) ? '0 : BEAR_W'(deg);
		end
	end

	assign en_o  = !out_v_q || result.ready;
	assign en_s7 = !v_s7 || vec_ready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || rot_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= points.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= rot_done;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_o)  out_v_q <= vec_done;
		end
	end

	assign points.ready   = en_s1;
	assign result.valid   = out_v_q;
	assign result.bearing = bearing_q;

	a_bear_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (DGW'(result.bearing) < FULL_D))
		else $error("bearing at or above a full turn");

	a_recip_err: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ((r_c[LANE_A] < 8'd135) && (r_c[LANE_B] < 8'd135) && (r_c[LANE_D] < 8'd135)))
		else $error("reciprocal estimate out of bounds");

	a_rot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rot_done && !en_s4 |=> rot_done)
		else $error("rotation chain dropped a stalled request");
endmodule
`default_nettype wire
